// ===== rtl/core/qvr_pkg.sv =====
// ============================================================================
// qvr_pkg
// Shared widths, types and register indexes for the quaternion vector rotator.
// ============================================================================
package qvr_pkg;

    localparam int VEC_W  = 32;                     // vector component width
    localparam int QUAT_W = 16;                     // quaternion component width
    localparam int SQ_W   = 2 * QUAT_W;             // quadratic term width
    localparam int COEF_W = SQ_W + 2;               // matrix coefficient width
    localparam int NORM_W = SQ_W + 1;               // squared magnitude width
    localparam int PROD_W = VEC_W + COEF_W;         // vector times coefficient
    localparam int SUM_W  = PROD_W + 2;             // row sum of three products
    localparam int HIGH_W = SUM_W - VEC_W;          // numerator bits above quotient
    localparam int TDATA_W = ((3 * VEC_W + 7) / 8) * 8;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_QUAT_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_QUAT_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_QUAT_Z = 2'd2;
    localparam logic [IDX_W-1:0] REG_QUAT_W = 2'd3;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [NORM_W-1:0] rem;
        logic [VEC_W-1:0]  lo;
        logic [VEC_W-1:0]  quo;
    } t_div_lane;

    typedef struct packed {
        logic              degen;
        logic [NORM_W-1:0] d;
    } t_div_ctl;

endpackage

// ===== rtl/core/quaternion_vector_rotate_unit.sv =====
// ============================================================================
// quaternion_vector_rotate_unit
// Rotates a stream of vectors by a configured quaternion, normalised by its
// squared magnitude, with rounding, saturation and a degenerate flag.
// ============================================================================
//  channel  | direction | content
//  s        | in        | tdata: vec_x, vec_y, vec_z; tuser: inverse
//  m        | out       | tdata: rot_x, rot_y, rot_z; tuser: saturated, degenerate
//  cfg      | in        | write of quat_x, quat_y, quat_z, quat_w by index
//
//  One transaction per cycle while the m side accepts; the restoring divider
//  yields one quotient bit per stage after the product and sum stages.
//  Synchronous active-low reset clears valid bits and sets the quaternion
//  to identity. A stall on the m side holds every stage; nothing is lost.
// ============================================================================
module quaternion_vector_rotate_unit
    import qvr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // vec_x, vec_y, vec_z
    input  logic               i_s_tuser,   // inverse
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // rot_x, rot_y, rot_z
    output logic [1:0]         o_m_tuser,   // saturated, degenerate
    input  logic               i_cfg_wr_en,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [QUAT_W-1:0]  i_cfg_wdata
);

    logic signed [QUAT_W-1:0] r_qx, r_qy, r_qz, r_qw;
    logic en;

    logic r_out_valid;
    logic [VEC_W-1:0] r_rot [0:2];
    logic r_sat, r_degen;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'({r_rot[2], r_rot[1], r_rot[0]});
    assign o_m_tuser  = {r_degen, r_sat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= QUAT_W'(16384);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_QUAT_X: r_qx <= i_cfg_wdata;
                REG_QUAT_Y: r_qy <= i_cfg_wdata;
                REG_QUAT_Z: r_qz <= i_cfg_wdata;
                REG_QUAT_W: r_qw <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: quadratic terms
    logic r1_v, r1_inv;
    logic signed [VEC_W-1:0] r1_vec [0:2];
    logic signed [SQ_W-1:0] r1_w2, r1_x2, r1_y2, r1_z2;
    logic signed [SQ_W-1:0] r1_xy, r1_xz, r1_yz, r1_wx, r1_wy, r1_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_inv    <= i_s_tuser;
            r1_vec[0] <= i_s_tdata[VEC_W-1:0];
            r1_vec[1] <= i_s_tdata[2*VEC_W-1:VEC_W];
            r1_vec[2] <= i_s_tdata[3*VEC_W-1:2*VEC_W];
            r1_w2 <= r_qw * r_qw;
            r1_x2 <= r_qx * r_qx;
            r1_y2 <= r_qy * r_qy;
            r1_z2 <= r_qz * r_qz;
            r1_xy <= r_qx * r_qy;
            r1_xz <= r_qx * r_qz;
            r1_yz <= r_qy * r_qz;
            r1_wx <= r_qw * r_qx;
            r1_wy <= r_qw * r_qy;
            r1_wz <= r_qw * r_qz;
        end
    end

    // stage 2: rotation matrix and squared magnitude
    logic r2_v;
    logic signed [VEC_W-1:0] r2_vec [0:2];
    logic signed [COEF_W-1:0] r2_m [0:2][0:2];
    logic [NORM_W-1:0] r2_n2;

    logic signed [COEF_W-1:0] e_w2, e_x2, e_y2, e_z2, e_xy, e_xz, e_yz;
    logic signed [COEF_W-1:0] e_wx, e_wy, e_wz, e_n2;

    always_comb begin
        e_w2 = COEF_W'(r1_w2);
        e_x2 = COEF_W'(r1_x2);
        e_y2 = COEF_W'(r1_y2);
        e_z2 = COEF_W'(r1_z2);
        e_xy = COEF_W'(r1_xy);
        e_xz = COEF_W'(r1_xz);
        e_yz = COEF_W'(r1_yz);
        e_wx = r1_inv ? -COEF_W'(r1_wx) : COEF_W'(r1_wx);
        e_wy = r1_inv ? -COEF_W'(r1_wy) : COEF_W'(r1_wy);
        e_wz = r1_inv ? -COEF_W'(r1_wz) : COEF_W'(r1_wz);
        e_n2 = e_w2 + e_x2 + e_y2 + e_z2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_vec     <= r1_vec;
            r2_n2      <= e_n2[NORM_W-1:0];
            r2_m[0][0] <= e_w2 + e_x2 - e_y2 - e_z2;
            r2_m[0][1] <= (e_xy - e_wz) <<< 1;
            r2_m[0][2] <= (e_xz + e_wy) <<< 1;
            r2_m[1][0] <= (e_xy + e_wz) <<< 1;
            r2_m[1][1] <= e_w2 - e_x2 + e_y2 - e_z2;
            r2_m[1][2] <= (e_yz - e_wx) <<< 1;
            r2_m[2][0] <= (e_xz - e_wy) <<< 1;
            r2_m[2][1] <= (e_yz + e_wx) <<< 1;
            r2_m[2][2] <= e_w2 - e_x2 - e_y2 + e_z2;
        end
    end

    // stage 3: nine products
    logic r3_v;
    logic signed [PROD_W-1:0] r3_p [0:2][0:2];
    logic [NORM_W-1:0] r3_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_n2 <= r2_n2;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_p[i][j] <= PROD_W'(r2_vec[j]) * PROD_W'(r2_m[i][j]);
                end
            end
        end
    end

    // stage 4: row sums as sign and magnitude
    logic r4_v;
    logic [SUM_W-1:0] r4_mag [0:2];
    logic r4_neg [0:2];
    logic [NORM_W-1:0] r4_n2;
    logic signed [SUM_W-1:0] n4_sum [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_sum[i] = SUM_W'(r3_p[i][0]) + SUM_W'(r3_p[i][1]) + SUM_W'(r3_p[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_n2 <= r3_n2;
            for (int i = 0; i < 3; i++) begin
                r4_neg[i] <= n4_sum[i][SUM_W-1];
                r4_mag[i] <= n4_sum[i][SUM_W-1] ? -n4_sum[i] : n4_sum[i];
            end
        end
    end

    // stage 5 and divider: one quotient bit per stage
    logic      r_dv [0:VEC_W];
    t_div_ctl  r_dc [0:VEC_W];
    t_div_lane r_dl [0:VEC_W][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dc[0].degen <= (r4_n2 == '0);
            r_dc[0].d     <= r4_n2;
            for (int i = 0; i < 3; i++) begin
                r_dl[0][i].neg <= r4_neg[i];
                r_dl[0][i].ovf <= r4_mag[i][SUM_W-1:VEC_W] >= HIGH_W'(r4_n2);
                r_dl[0][i].rem <= r4_mag[i][VEC_W+NORM_W-1:VEC_W];
                r_dl[0][i].lo  <= r4_mag[i][VEC_W-1:0];
                r_dl[0][i].quo <= '0;
            end
        end
    end

    for (genvar k = 0; k < VEC_W; k++) begin : g_div
        logic [NORM_W:0] t [0:2];
        logic [NORM_W:0] diff [0:2];
        logic            ge [0:2];
        t_div_lane       n_dl [0:2];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i]    = {r_dl[k][i].rem, r_dl[k][i].lo[VEC_W-1]};
                diff[i] = t[i] - {1'b0, r_dc[k].d};
                ge[i]   = t[i] >= {1'b0, r_dc[k].d};
                n_dl[i].neg = r_dl[k][i].neg;
                n_dl[i].ovf = r_dl[k][i].ovf;
                n_dl[i].rem = ge[i] ? diff[i][NORM_W-1:0] : t[i][NORM_W-1:0];
                n_dl[i].lo  = {r_dl[k][i].lo[VEC_W-2:0], 1'b0};
                n_dl[i].quo = {r_dl[k][i].quo[VEC_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dc[k+1] <= r_dc[k];
                r_dl[k+1] <= n_dl;
            end
        end
    end

    // output stage: round, saturate, zero on degenerate
    localparam logic [VEC_W:0] HALF = (VEC_W+1)'(1) << (VEC_W - 1);

    logic [NORM_W:0] f_rem2 [0:2];
    logic [VEC_W:0]  f_quo  [0:2];
    logic [VEC_W:0]  f_neg  [0:2];
    logic [VEC_W-1:0] f_rot [0:2];
    logic f_clip [0:2];
    logic f_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_rem2[i] = {r_dl[VEC_W][i].rem, 1'b0};
            f_quo[i]  = (VEC_W+1)'(r_dl[VEC_W][i].quo)
                      + (VEC_W+1)'(f_rem2[i] >= {1'b0, r_dc[VEC_W].d});
            f_neg[i]  = -f_quo[i];
            if (r_dc[VEC_W].degen) begin
                f_clip[i] = 1'b0;
                f_rot[i]  = '0;
            end else if (r_dl[VEC_W][i].neg) begin
                f_clip[i] = r_dl[VEC_W][i].ovf || (f_quo[i] > HALF);
                f_rot[i]  = f_clip[i] ? HALF[VEC_W-1:0] : f_neg[i][VEC_W-1:0];
            end else begin
                f_clip[i] = r_dl[VEC_W][i].ovf || (f_quo[i] > HALF - 1'b1);
                f_rot[i]  = f_clip[i] ? ~HALF[VEC_W-1:0] : f_quo[i][VEC_W-1:0];
            end
        end
        f_sat = f_clip[0] || f_clip[1] || f_clip[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[VEC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot   <= f_rot;
            r_sat   <= f_sat;
            r_degen <= r_dc[VEC_W].degen;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stream test of the quaternion vector rotator: random and directed vectors
// under a series of quaternion settings, checked against a bit-exact predictor
// of the normalised rotation, rounding, saturation and degenerate flag.
// ============================================================================
module tb;
    import qvr_pkg::*;

    localparam int LATENCY   = VEC_W + 6;
    localparam int CYCLE_CAP = 600000;

    typedef struct {
        logic [VEC_W-1:0] x, y, z;
        logic             inv;
    } t_vec;

    typedef struct {
        logic [VEC_W-1:0] x, y, z;
        logic             sat, degen;
    } t_rot;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata = '0;   // vec_x, vec_y, vec_z
    logic               i_s_tuser = 1'b0; // inverse
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;        // rot_x, rot_y, rot_z
    logic [1:0]         o_m_tuser;        // saturated, degenerate
    logic               i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [QUAT_W-1:0]  i_cfg_wdata = '0;

    logic signed [QUAT_W-1:0] q_x = 0, q_y = 0, q_z = 0, q_w = 16384;

    t_vec pending_vecs[$];
    t_rot expected_rots[$];
    int   fail_count = 0;
    int   rots_seen = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;
    int   tx_gap = 0;
    int   rx_hold = 0;
    bit   long_hold_done = 1'b0;

    quaternion_vector_rotate_unit u_top (.*);

    always #6 i_clk = ~i_clk;

    function automatic t_rot rotate_vec(t_vec v);
        longint w, x, y, z, w2, x2, y2, z2, n2;
        longint c[3][3];
        logic signed [127:0] vs[3];
        logic signed [127:0] acc;
        logic [127:0] mag, quo, rem;
        logic [VEC_W-1:0] comp[3];
        t_rot r;
        w = q_w; x = q_x; y = q_y; z = q_z;
        if (v.inv) begin
            x = -x; y = -y; z = -z;
        end
        w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
        n2 = w2 + x2 + y2 + z2;
        r.sat = 1'b0;
        r.degen = 1'b0;
        if (n2 == 0) begin
            r.x = '0; r.y = '0; r.z = '0; r.degen = 1'b1;
            return r;
        end
        c[0][0] = w2 + x2 - y2 - z2;
        c[0][1] = 2 * (x * y - w * z);
        c[0][2] = 2 * (x * z + w * y);
        c[1][0] = 2 * (x * y + w * z);
        c[1][1] = w2 - x2 + y2 - z2;
        c[1][2] = 2 * (y * z - w * x);
        c[2][0] = 2 * (x * z - w * y);
        c[2][1] = 2 * (y * z + w * x);
        c[2][2] = w2 - x2 - y2 + z2;
        vs[0] = {{(128-VEC_W){v.x[VEC_W-1]}}, v.x};
        vs[1] = {{(128-VEC_W){v.y[VEC_W-1]}}, v.y};
        vs[2] = {{(128-VEC_W){v.z[VEC_W-1]}}, v.z};
        for (int i = 0; i < 3; i++) begin
            acc = vs[0] * 128'(signed'(c[i][0])) + vs[1] * 128'(signed'(c[i][1]))
                + vs[2] * 128'(signed'(c[i][2]));
            mag = (acc < 0) ? 128'(-acc) : 128'(acc);
            quo = mag / 128'(n2);
            rem = mag % 128'(n2);
            if (2 * rem >= 128'(n2))
                quo = quo + 1;
            if (acc < 0) begin
                if (quo > (128'd1 << (VEC_W - 1))) begin
                    quo = 128'd1 << (VEC_W - 1);
                    r.sat = 1'b1;
                end
                comp[i] = VEC_W'(-quo);
            end else begin
                if (quo > (128'd1 << (VEC_W - 1)) - 1) begin
                    quo = (128'd1 << (VEC_W - 1)) - 1;
                    r.sat = 1'b1;
                end
                comp[i] = VEC_W'(quo);
            end
        end
        r.x = comp[0]; r.y = comp[1]; r.z = comp[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("quaternion_vector_rotate_unit verification failed");
            $finish;
        end
    end

    // sender
    always @(posedge i_clk) begin
        t_vec v;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (tx_gap > 0) begin
                i_s_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (pending_vecs.size() > 0) begin
                v = pending_vecs.pop_front();
                i_s_tdata <= {v.z, v.y, v.x};
                i_s_tuser <= v.inv;
                i_s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0)
                    tx_gap <= $urandom_range(1, 18);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!long_hold_done && rots_seen > 300) begin
            i_m_tready <= 1'b0;
            rx_hold <= 400;
            long_hold_done <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 17);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_vec v;
        t_rot e;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            v.x = i_s_tdata[VEC_W-1:0];
            v.y = i_s_tdata[2*VEC_W-1:VEC_W];
            v.z = i_s_tdata[3*VEC_W-1:2*VEC_W];
            v.inv = i_s_tuser;
            expected_rots.push_back(rotate_vec(v));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rots_seen <= rots_seen + 1;
            if (expected_rots.size() == 0) begin
                $display("%0t: unexpected transaction %h/%b", $time, o_m_tdata, o_m_tuser);
                fail_count <= fail_count + 1;
            end else begin
                e = expected_rots.pop_front();
                if ({e.z, e.y, e.x} !== o_m_tdata[3*VEC_W-1:0]
                        || {e.degen, e.sat} !== o_m_tuser) begin
                    $display("%0t: expected x %h y %h z %h sat %b degen %b", $time,
                             e.x, e.y, e.z, e.sat, e.degen);
                    $display("%0t: actual   x %h y %h z %h sat %b degen %b", $time,
                             o_m_tdata[VEC_W-1:0], o_m_tdata[2*VEC_W-1:VEC_W],
                             o_m_tdata[3*VEC_W-1:2*VEC_W], o_m_tuser[0], o_m_tuser[1]);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [QUAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_QUAT_X: q_x = val;
            REG_QUAT_Y: q_y = val;
            REG_QUAT_Z: q_z = val;
            REG_QUAT_W: q_w = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_vecs.size() > 0 || expected_rots.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_quat(logic [QUAT_W-1:0] x, y, z, w);
        wait_idle();
        write_reg(REG_QUAT_X, x);
        write_reg(REG_QUAT_Y, y);
        write_reg(REG_QUAT_Z, z);
        write_reg(REG_QUAT_W, w);
    endtask

    function automatic logic [QUAT_W-1:0] pick_quat();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h0001;
            4: return 16'hffff;
            5: return 16'h4000;
            default: return QUAT_W'($urandom);
        endcase
    endfunction

    function automatic logic [VEC_W-1:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4, 5: return VEC_W'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return VEC_W'($urandom);
        endcase
    endfunction

    task automatic add_vec(logic [VEC_W-1:0] x, y, z, logic inv);
        t_vec v;
        v.x = x; v.y = y; v.z = z; v.inv = inv;
        pending_vecs.push_back(v);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            add_vec(pick_comp(), pick_comp(), pick_comp(), 1'($urandom));
    endtask

    task automatic add_extremes();
        add_vec(32'h0, 32'h0, 32'h0, 1'b0);
        add_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        add_vec(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        add_vec(32'hffff_ffff, 32'h0000_0001, 32'hfffe_0000, 1'b0);
    endtask

    initial begin
        logic [QUAT_W-1:0] qa, qb, qc, qd;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset
        add_extremes();
        add_vec(32'h0003_8000, 32'hfff2_4000, 32'h1234_5678, 1'b1);
        // 90 degrees about z, forward and inverse
        set_quat(16'h0, 16'h0, 16'h2d41, 16'h2d41);
        add_extremes();
        add_vec(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        add_vec(32'h0001_0000, 32'h0, 32'h0, 1'b1);
        // zero quaternion
        set_quat(16'h0, 16'h0, 16'h0, 16'h0);
        add_extremes();
        // all components at the negative extreme
        set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_extremes();
        // tiny non-unit quaternion with a large vector: clipping
        set_quat(16'h0001, 16'h0, 16'h0, 16'h0001);
        add_extremes();
        add_vec(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);

        for (int p = 0; p < 9; p++) begin
            qa = pick_quat(); qb = pick_quat(); qc = pick_quat(); qd = pick_quat();
            set_quat(qa, qb, qc, qd);
            add_random(140);
        end
        set_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_random(60);
        quiet = 1'b1;
        set_quat(pick_quat(), pick_quat(), pick_quat(), pick_quat());
        add_random(100);

        wait_idle();
        if (fail_count == 0)
            $display("quaternion_vector_rotate_unit verification clean");
        else
            $display("quaternion_vector_rotate_unit verification failed");
        $finish;
    end
endmodule
